FILE: sv/irpdt_pkg.sv
// ----------------------------------------------------------------------------
// irpdt_pkg: shared types and constants of the pulse-distance IR transmitter
// Register indexes, reset values, segment codes and the control structs that
// pass between the configuration block, the waveform core and the top level.
// ----------------------------------------------------------------------------
package irpdt_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_CARRIER_HALF = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEADER_MARK  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEADER_SPACE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNIT_MARK    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNIT_SPACE   = 3'd4;

   localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
   localparam logic [9:0]  RST_LEADER_MARK  = 10'd346;
   localparam logic [15:0] RST_LEADER_SPACE = 16'd4500;
   localparam logic [7:0]  RST_UNIT_MARK    = 8'd21;
   localparam logic [13:0] RST_UNIT_SPACE   = 14'd562;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SEND = 1'b1;

   localparam int RSP_DATA_W = 8;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD_MARK,
      PH_LEAD_SPACE,
      PH_BIT_MARK,
      PH_BIT_SPACE,
      PH_STOP_MARK
   } phase_type;

   typedef struct packed {
      logic [7:0]  carrier_half_ticks;
      logic [9:0]  leader_mark_cycles;
      logic [15:0] leader_space_ticks;
      logic [7:0]  unit_mark_cycles;
      logic [13:0] unit_space_ticks;
   } cfg_type;

   typedef struct packed {
      logic request_rejected;
      logic frame_done;
      logic busy_res;
      logic led_on;
   } result_type;

endpackage

FILE: sv/irpdt_csr.sv
// ----------------------------------------------------------------------------
// irpdt_csr: timing registers of the IR transmitter
// Holds the five frame timing values; a write lands at the clock edge at which
// the write enable is high. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module irpdt_csr
   import irpdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CARRIER_HALF: cfg_in.carrier_half_ticks = csr_wdata[7:0];
            CSR_LEADER_MARK:  cfg_in.leader_mark_cycles = csr_wdata[9:0];
            CSR_LEADER_SPACE: cfg_in.leader_space_ticks = csr_wdata[15:0];
            CSR_UNIT_MARK:    cfg_in.unit_mark_cycles   = csr_wdata[7:0];
            CSR_UNIT_SPACE:   cfg_in.unit_space_ticks   = csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_half_ticks <= RST_CARRIER_HALF;
         cfg_ff.leader_mark_cycles <= RST_LEADER_MARK;
         cfg_ff.leader_space_ticks <= RST_LEADER_SPACE;
         cfg_ff.unit_mark_cycles   <= RST_UNIT_MARK;
         cfg_ff.unit_space_ticks   <= RST_UNIT_SPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/irpdt_core.sv
// ----------------------------------------------------------------------------
// irpdt_core: frame sequencer and carrier generator
// Holds the segment state, the code shift register and the carrier counters,
// and advances them by one word per enabled cycle. Segments of zero length
// are skipped in the same cycle in which they would be entered.
// ----------------------------------------------------------------------------
module irpdt_core
   import irpdt_pkg::*;
#(
   parameter int CODE_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        step_en,
   input  logic        kind,
   input  logic [31:0] code,
   output result_type  res,
   output logic        busy
);

   localparam int BLW = $clog2(CODE_BITS + 1);

   phase_type              phase_ff, phase_in;
   logic [CODE_BITS-1:0]   shift_ff, shift_in, shift_nb;
   logic [BLW-1:0]         bits_ff, bits_in, bits_nb;
   logic [15:0]            space_ff, space_in, space_step, space_lim, bit_len;
   logic [9:0]             cycle_ff, cycle_in, cyc_step, mark_lim;
   logic [7:0]             half_ff, half_in, half_step, half_lim;
   logic                   level_ff, level_in, lvl_step;
   logic                   mark_end, space_end, enter_seg, done, rej;
   logic                   um_zero, us_zero;

   // Entry into a bit cell: stop mark once all bits are out; with no mark
   // length the cell starts at its space; with neither, all remaining bits
   // and the stop mark collapse and the frame ends at once.
   function automatic phase_type bit_entry(input logic no_bits, input logic m_zero,
                                           input logic s_zero);
      phase_type p;
      if (no_bits) begin
         p = m_zero ? PH_IDLE : PH_STOP_MARK;
      end else if (!m_zero) begin
         p = PH_BIT_MARK;
      end else if (!s_zero) begin
         p = PH_BIT_SPACE;
      end else begin
         p = PH_IDLE;
      end
      return p;
   endfunction

   always_comb begin
      um_zero  = (cfg.unit_mark_cycles == 8'd0);
      us_zero  = (cfg.unit_space_ticks == 14'd0);
      half_lim = (cfg.carrier_half_ticks == 8'd0) ? 8'd1 : cfg.carrier_half_ticks;
      bit_len  = shift_ff[CODE_BITS-1]
               ? 16'({cfg.unit_space_ticks, 1'b0}) + 16'(cfg.unit_space_ticks)
               : 16'(cfg.unit_space_ticks);
      mark_lim = (phase_ff == PH_LEAD_MARK) ? cfg.leader_mark_cycles
                                            : 10'(cfg.unit_mark_cycles);
      space_lim = (phase_ff == PH_LEAD_SPACE) ? cfg.leader_space_ticks : bit_len;

      // The carrier starts high; a cycle is counted when a low half ends.
      half_step = half_ff + 8'd1;
      cyc_step  = cycle_ff;
      lvl_step  = level_ff;
      if (half_step >= half_lim) begin
         half_step = 8'd0;
         if (level_ff) begin
            lvl_step = 1'b0;
         end else begin
            lvl_step = 1'b1;
            cyc_step = cycle_ff + 10'd1;
         end
      end
      mark_end   = (cyc_step >= mark_lim);
      space_step = space_ff + 16'd1;
      space_end  = (space_step >= space_lim);
      shift_nb   = shift_ff << 1;
      bits_nb    = (bits_ff == '0) ? bits_ff : bits_ff - BLW'(1);

      phase_in  = phase_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      space_in  = space_ff;
      cycle_in  = cycle_ff;
      half_in   = half_ff;
      level_in  = level_ff;
      enter_seg = 1'b0;
      done      = 1'b0;
      rej       = 1'b0;

      if (step_en) begin
         if (kind == KIND_SEND) begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               shift_in  = CODE_BITS'(code);
               bits_in   = BLW'(CODE_BITS);
               enter_seg = 1'b1;
               if (cfg.leader_mark_cycles != 10'd0) begin
                  phase_in = PH_LEAD_MARK;
               end else if (cfg.leader_space_ticks != 16'd0) begin
                  phase_in = PH_LEAD_SPACE;
               end else begin
                  phase_in = bit_entry(1'b0, um_zero, us_zero);
               end
            end
         end else begin
            case (phase_ff)
               PH_LEAD_MARK: begin
                  half_in  = half_step;
                  cycle_in = cyc_step;
                  level_in = lvl_step;
                  if (mark_end) begin
                     enter_seg = 1'b1;
                     phase_in  = (cfg.leader_space_ticks != 16'd0) ? PH_LEAD_SPACE
                               : bit_entry(bits_ff == '0, um_zero, us_zero);
                  end
               end
               PH_LEAD_SPACE: begin
                  space_in = space_step;
                  if (space_end) begin
                     enter_seg = 1'b1;
                     phase_in  = bit_entry(bits_ff == '0, um_zero, us_zero);
                  end
               end
               PH_BIT_MARK: begin
                  half_in  = half_step;
                  cycle_in = cyc_step;
                  level_in = lvl_step;
                  if (mark_end) begin
                     enter_seg = 1'b1;
                     if (bit_len != 16'd0) begin
                        phase_in = PH_BIT_SPACE;
                     end else begin
                        shift_in = shift_nb;
                        bits_in  = bits_nb;
                        phase_in = bit_entry(bits_nb == '0, um_zero, us_zero);
                     end
                  end
               end
               PH_BIT_SPACE: begin
                  space_in = space_step;
                  if (space_end) begin
                     enter_seg = 1'b1;
                     shift_in  = shift_nb;
                     bits_in   = bits_nb;
                     phase_in  = bit_entry(bits_nb == '0, um_zero, us_zero);
                  end
               end
               PH_STOP_MARK: begin
                  half_in  = half_step;
                  cycle_in = cyc_step;
                  level_in = lvl_step;
                  if (mark_end) begin
                     enter_seg = 1'b1;
                     phase_in  = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end

         if (enter_seg) begin
            space_in = 16'd0;
            cycle_in = 10'd0;
            half_in  = 8'd0;
            level_in = (phase_in == PH_LEAD_MARK) || (phase_in == PH_BIT_MARK)
                    || (phase_in == PH_STOP_MARK);
            done     = (phase_in == PH_IDLE);
         end
      end

      res.led_on           = (phase_in != PH_IDLE) && level_in;
      res.busy_res         = (phase_in != PH_IDLE);
      res.frame_done       = done;
      res.request_rejected = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         bits_ff  <= '0;
         space_ff <= '0;
         cycle_ff <= '0;
         half_ff  <= '0;
         level_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         space_ff <= space_in;
         cycle_ff <= cycle_in;
         half_ff  <= half_in;
         level_ff <= level_in;
      end
   end

   assign busy = (phase_ff != PH_IDLE);

endmodule

FILE: sv/ir_pulse_distance_transmitter.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter: NEC-style pulse-distance IR transmitter
// Streams one word per microsecond tick or send request and answers each
// word with the LED level and the frame status after it.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one word per tick (req_tuser = 0) or a send request
//   (req_tuser = 1, code in req_tdata). rsp_ returns exactly one word for
//   each req_ word, in order: LED level, busy, rejected, and tlast on the
//   word that ends a frame. The code goes out MSB first.
//   An accepted req_ word is held in the input register, and the segment
//   logic loads its result into the output register, which shows the rsp_
//   word. Throughput is one word per cycle while rsp_tready is high; the
//   only loop is the update of the segment state and carrier counters.
//   When rsp_tready is low the output register holds its word and the input
//   register still takes one more word, after which req_tready drops.
//   Reset empties both registers, returns the sequencer to idle with the LED
//   off and loads the timing registers with 13, 346, 4500, 21 and 562.
//   The csr_ port writes one timing register per cycle at csr_addr; write
//   only while no word is in flight.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter
   import irpdt_pkg::*;
#(
   parameter int CODE_BITS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] code
   input  logic                  req_tuser,   // [0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] led_on, [1] busy_res,
                                              // [2] request_rejected, [7:3] zero
   output logic                  rsp_tlast,   // frame_done
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   result_type  core_res;
   logic        core_busy;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff;
   logic [31:0] s1_code_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff;
   logic        adv;
   logic        req_fire;

   irpdt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irpdt_core #(
      .CODE_BITS (CODE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (adv),
      .kind    (s1_kind_ff),
      .code    (s1_code_ff),
      .res     (core_res),
      .busy    (core_busy)
   );

   // A word leaves the input register whenever the output register is free
   // or is emptied in the same cycle.
   assign adv        = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_tuser;
         s1_code_ff <= req_tdata;
      end
      if (adv) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_res_ff.request_rejected, out_res_ff.busy_res,
                        out_res_ff.led_on};
   assign rsp_tlast  = out_res_ff.frame_done;

`ifndef SYNTHESIS
   // A send request that meets a running frame is flagged and leaves it running.
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      adv && (s1_kind_ff == KIND_SEND) && core_busy
      |=> rsp_tvalid && rsp_tdata[2] && rsp_tdata[1] && !rsp_tlast)
      else $error("send request during a frame was not rejected");

   // A tick while idle gives an all-zero word.
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      adv && (s1_kind_ff == KIND_TICK) && !core_busy
      |=> rsp_tvalid && (rsp_tdata == '0) && !rsp_tlast)
      else $error("tick while idle produced a nonzero word");

   // A word waiting in the input register is neither lost nor overwritten.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv |=> s1_valid_ff && $stable(s1_code_ff)
                              && $stable(s1_kind_ff))
      else $error("stalled input word was lost or changed");
`endif

endmodule

FILE: bench/ir_pulse_distance_transmitter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_test: self-checking bench for the IR transmitter
// Drives tick and send words into the transmitter, predicts the LED level and
// frame status after every word with a local model of the frame sequencer,
// and compares each response word field by field. Timing registers are
// reloaded between phases, mid-frame included, with random stalls on both
// streams and one long hold-off on the response side.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_test;
   import irpdt_pkg::*;

   localparam int CODE_WIDTH = 32;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;      // [31:0] code
   logic req_tuser = KIND_TICK;      // [0] kind
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata; // [0] led_on, [1] busy_res, [2] request_rejected
   logic rsp_tlast;                  // frame_done
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ir_pulse_distance_transmitter dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Expected status words, oldest first, and the local copy of the sequencer.
   result_type pending[$];
   result_type want;
   cfg_type timing = '{RST_CARRIER_HALF, RST_LEADER_MARK, RST_LEADER_SPACE,
                       RST_UNIT_MARK, RST_UNIT_SPACE};
   phase_type tx_phase = PH_IDLE;
   logic [CODE_WIDTH-1:0] tx_code = '0;
   int unsigned tx_bits_left = 0;
   int unsigned tx_space = 0;
   int unsigned tx_cycles = 0;
   int unsigned tx_half = 0;
   bit tx_level = 1'b0;

   int errors = 0;
   int cycle_total = 0;
   int rsp_hold_cycles = 0;
   int rsp_stall = 0;
   bit quiet = 1'b0;

   // ---------------------------------------------------------------- sequencer model

   function automatic int unsigned bit_space_len();
      return tx_code[CODE_WIDTH-1] ? 3 * timing.unit_space_ticks : timing.unit_space_ticks;
   endfunction

   function automatic void shift_out();
      tx_code = tx_code << 1;
      if (tx_bits_left > 0) tx_bits_left--;
   endfunction

   // Enters a segment, skipping any of zero length; returns 1 if the frame ends.
   function automatic bit enter_segment(phase_type start);
      phase_type seg;
      bit settled;
      bit ended;
      seg = start;
      settled = 0;
      ended = 0;
      tx_space = 0;
      tx_cycles = 0;
      tx_half = 0;
      tx_level = 0;
      while (!settled) begin
         case (seg)
            PH_LEAD_MARK: begin
               if (timing.leader_mark_cycles != 0) begin
                  tx_phase = seg;
                  tx_level = 1;
                  settled = 1;
               end else begin
                  seg = PH_LEAD_SPACE;
               end
            end
            PH_LEAD_SPACE: begin
               if (timing.leader_space_ticks != 0) begin
                  tx_phase = seg;
                  settled = 1;
               end else begin
                  seg = PH_BIT_MARK;
               end
            end
            PH_BIT_MARK: begin
               if (tx_bits_left == 0) begin
                  seg = PH_STOP_MARK;
               end else if (timing.unit_mark_cycles != 0) begin
                  tx_phase = seg;
                  tx_level = 1;
                  settled = 1;
               end else begin
                  seg = PH_BIT_SPACE;
               end
            end
            PH_BIT_SPACE: begin
               if (bit_space_len() != 0) begin
                  tx_phase = seg;
                  settled = 1;
               end else begin
                  shift_out();
                  seg = PH_BIT_MARK;
               end
            end
            PH_STOP_MARK: begin
               if (timing.unit_mark_cycles != 0) begin
                  tx_phase = seg;
                  tx_level = 1;
               end else begin
                  tx_phase = PH_IDLE;
                  ended = 1;
               end
               settled = 1;
            end
            default: begin
               tx_phase = PH_IDLE;
               ended = 1;
               settled = 1;
            end
         endcase
      end
      return ended;
   endfunction

   // A carrier cycle is counted when the level goes from low back to high.
   function automatic bit carrier_tick(int unsigned cycles);
      int unsigned half;
      half = (timing.carrier_half_ticks != 0) ? timing.carrier_half_ticks : 1;
      tx_half++;
      if (tx_half >= half) begin
         tx_half = 0;
         if (tx_level) begin
            tx_level = 0;
         end else begin
            tx_level = 1;
            tx_cycles++;
         end
      end
      return tx_cycles >= cycles;
   endfunction

   function automatic bit silent_tick(int unsigned len);
      tx_space++;
      return tx_space >= len;
   endfunction

   function automatic result_type predict_word(logic kind, logic [31:0] code);
      result_type status;
      phase_type next_seg;
      bit ended;
      bit done;
      bit rejected;
      next_seg = PH_IDLE;
      ended = 0;
      done = 0;
      rejected = 0;
      if (kind == KIND_SEND) begin
         if (tx_phase != PH_IDLE) begin
            rejected = 1;
         end else begin
            tx_code = code[CODE_WIDTH-1:0];
            tx_bits_left = CODE_WIDTH;
            done = enter_segment(PH_LEAD_MARK);
         end
      end else begin
         case (tx_phase)
            PH_LEAD_MARK: begin
               ended = carrier_tick(timing.leader_mark_cycles);
               next_seg = PH_LEAD_SPACE;
            end
            PH_LEAD_SPACE: begin
               ended = silent_tick(timing.leader_space_ticks);
               next_seg = PH_BIT_MARK;
            end
            PH_BIT_MARK: begin
               ended = carrier_tick(timing.unit_mark_cycles);
               next_seg = PH_BIT_SPACE;
            end
            PH_BIT_SPACE: begin
               ended = silent_tick(bit_space_len());
               if (ended) shift_out();
               next_seg = PH_BIT_MARK;
            end
            PH_STOP_MARK: begin
               ended = carrier_tick(timing.unit_mark_cycles);
               next_seg = PH_IDLE;
            end
            default: ;
         endcase
         if (ended) begin
            if (next_seg == PH_IDLE) begin
               tx_phase = PH_IDLE;
               tx_level = 0;
               tx_half = 0;
               tx_cycles = 0;
               done = 1;
            end else begin
               done = enter_segment(next_seg);
            end
         end
      end
      status.led_on = (tx_phase != PH_IDLE) && tx_level;
      status.busy_res = (tx_phase != PH_IDLE);
      status.frame_done = done;
      status.request_rejected = rejected;
      return status;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int idle_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Valid is left high after the handshake; a gap before the next word or settle() drops it.
   task automatic send_word(input logic kind, input logic [31:0] code);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending.push_back(predict_word(kind, code));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_word(KIND_TICK, $urandom());
   endtask

   task automatic finish_frame();
      while (tx_phase != PH_IDLE) send_word(KIND_TICK, $urandom());
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write enable stays high across a burst; load_timing lowers it at the end.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx, input int unsigned value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_CARRIER_HALF: timing.carrier_half_ticks = value[7:0];
         CSR_LEADER_MARK:  timing.leader_mark_cycles = value[9:0];
         CSR_LEADER_SPACE: timing.leader_space_ticks = value[15:0];
         CSR_UNIT_MARK:    timing.unit_mark_cycles = value[7:0];
         CSR_UNIT_SPACE:   timing.unit_space_ticks = value[13:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_timing(input int unsigned half, input int unsigned lead_mark,
                              input int unsigned lead_space, input int unsigned unit_mark,
                              input int unsigned unit_space);
      csr_write(CSR_CARRIER_HALF, half);
      csr_write(CSR_LEADER_MARK, lead_mark);
      csr_write(CSR_LEADER_SPACE, lead_space);
      csr_write(CSR_UNIT_MARK, unit_mark);
      csr_write(CSR_UNIT_SPACE, unit_space);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_default_frame();
      quiet = 1;
      send_ticks(3);
      send_word(KIND_SEND, $urandom());
      send_ticks(100);
      send_word(KIND_SEND, $urandom());
      // The leader burst is under way; short timing brings the frame to its end.
      settle();
      load_timing(1, 1, 1, 1, 1);
      finish_frame();
      send_ticks(2);
      quiet = 0;
   endtask

   task automatic test_zero_lengths();
      settle();
      load_timing(0, 0, 0, 0, 0);
      send_word(KIND_SEND, 32'hFFFF_FFFF);
      send_ticks(2);
      settle();
      load_timing(1, 0, 0, 1, 0);
      send_word(KIND_SEND, 32'h0000_0000);
      finish_frame();
      settle();
      load_timing(2, 3, 0, 0, 2);
      send_word(KIND_SEND, 32'hFFFF_0000);
      finish_frame();
   endtask

   task automatic test_bit_values();
      settle();
      load_timing(1, 1, 1, 1, 1);
      send_word(KIND_SEND, 32'h0000_0000);
      finish_frame();
      send_word(KIND_SEND, 32'hFFFF_FFFF);
      finish_frame();
      send_word(KIND_SEND, 32'hAAAA_AAAA);
      send_word(KIND_SEND, 32'h5555_5555);
      finish_frame();
      send_word(KIND_SEND, 32'h5555_5555);
      finish_frame();
   endtask

   // Every register at its top value, then cut short by writes made mid-frame.
   task automatic test_long_segments();
      settle();
      quiet = 1;
      load_timing(255, 1023, 65535, 255, 16383);
      send_word(KIND_SEND, 32'h8000_0000 | $urandom());
      send_ticks(300);
      send_word(KIND_SEND, $urandom());
      settle();
      load_timing(255, 0, 65535, 255, 16383);
      send_ticks(100);
      settle();
      load_timing(0, 1, 100, 1, 16383);
      send_ticks(50);
      settle();
      load_timing(1, 1, 100, 1, 1);
      finish_frame();
      quiet = 0;
   endtask

   // The receiver stops for a long stretch while words keep coming.
   task automatic test_output_hold();
      settle();
      load_timing(1, 2, 3, 1, 1);
      quiet = 1;
      rsp_hold_cycles = 300;
      send_word(KIND_SEND, $urandom());
      send_ticks(80);
      quiet = 0;
      finish_frame();
   endtask

   task automatic test_random_traffic();
      for (int phase_no = 0; phase_no < 7; phase_no++) begin
         settle();
         load_timing($urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 8),
                     $urandom_range(0, 3), $urandom_range(0, 5));
         quiet = (phase_no == 3);
         for (int n = 0; n < 30; n++) begin
            if ($urandom_range(0, (tx_phase == PH_IDLE) ? 3 : 40) == 0) begin
               send_word(KIND_SEND, $urandom());
            end else begin
               send_word(KIND_TICK, $urandom());
            end
         end
      end
      quiet = 0;
      finish_frame();
   endtask

   // ---------------------------------------------------------------- response side

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall = idle_gap();
            rsp_tready <= (rsp_stall == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic expected, input logic actual);
      if (actual !== expected) begin
         $error("%s: expected %0b, got %0b", name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            $error("response word with no expected status waiting");
            errors++;
         end else begin
            want = pending.pop_front();
            check_field("led_on", want.led_on, rsp_tdata[0]);
            check_field("busy_res", want.busy_res, rsp_tdata[1]);
            check_field("request_rejected", want.request_rejected, rsp_tdata[2]);
            check_field("frame_done", want.frame_done, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      cycle_total++;
      if (cycle_total > CYCLE_LIMIT) begin
         $display("ir_pulse_distance_transmitter_test: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_frame();
      test_zero_lengths();
      test_bit_values();
      test_long_segments();
      test_output_hold();
      test_random_traffic();
      settle();
      repeat (10) @(posedge clock);
      if (pending.size() != 0) begin
         $error("%0d expected status words never arrived", pending.size());
         errors++;
      end
      if (errors == 0) begin
         $display("ir_pulse_distance_transmitter_test: PASS");
      end else begin
         $display("ir_pulse_distance_transmitter_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/irpdt_pkg.sv
sv/irpdt_csr.sv
sv/irpdt_core.sv
sv/ir_pulse_distance_transmitter.sv
bench/ir_pulse_distance_transmitter_test.sv
